// ===== design/hswbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hswbs_pkg
// shared types and constants for the sorting and search block
// ----------------------------------------------------------------------------
`default_nettype none

package hswbs_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;

    // input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // result kind codes
    localparam logic KIND_SORTED = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // position reported when a key is not found
    localparam logic signed [POS_W-1:0] POS_NONE = '1;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SWAP,
        CELL_ROTATE,
        CELL_MATCH
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic                       phase;
        logic signed [DATA_W-1:0]   data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/hswbs_cell.sv =====
// ----------------------------------------------------------------------------
// hswbs_cell
// one storage cell of the row: load, compare-exchange with neighbors,
// rotate toward cell zero, and key compare flags
// ----------------------------------------------------------------------------
`default_nettype none

module hswbs_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  wire logic                                   clk,
    input  wire hswbs_pkg::cell_ctrl_t                  ctrl,
    input  wire logic [CNT_W-1:0]                       count,
    input  wire logic signed [hswbs_pkg::DATA_W-1:0]    left_val,
    input  wire logic signed [hswbs_pkg::DATA_W-1:0]    right_val,
    input  wire logic signed [hswbs_pkg::DATA_W-1:0]    head_val,
    input  wire logic                                   gt_in,
    output logic signed [hswbs_pkg::DATA_W-1:0]         val,
    output logic                                        gt_out,
    output logic                                        eq_flag,
    output logic                                        lt_flag
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX1_C = CNT_W'(IDX + 1);

    logic signed [hswbs_pkg::DATA_W-1:0] val_reg;
    logic signed [hswbs_pkg::DATA_W-1:0] val_next;
    logic                                eq_reg;
    logic                                lt_reg;
    logic                                swap_lo;
    logic                                swap_hi;

    assign gt_out  = val_reg > right_val;
    assign val     = val_reg;
    assign eq_flag = eq_reg;
    assign lt_flag = lt_reg;

    // lower member of an active pair takes the right value, upper takes the left
    assign swap_lo = (IDX_C[0] == ctrl.phase) && (IDX1_C < count) && gt_out;
    assign swap_hi = (IDX_C[0] != ctrl.phase) && (IDX_C != '0) && (IDX_C < count) && gt_in;

    always_comb
    begin
        val_next = val_reg;
        unique case (ctrl.op)
            hswbs_pkg::CELL_LOAD:
            begin
                if (IDX_C == count)
                begin
                    val_next = ctrl.data;
                end
            end
            hswbs_pkg::CELL_SWAP:
            begin
                if (swap_lo)
                begin
                    val_next = right_val;
                end
                else if (swap_hi)
                begin
                    val_next = left_val;
                end
            end
            hswbs_pkg::CELL_ROTATE:
            begin
                val_next = (IDX1_C == count) ? head_val : right_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (ctrl.op == hswbs_pkg::CELL_MATCH)
        begin
            eq_reg <= val_reg == ctrl.data;
            lt_reg <= ctrl.data < val_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/heap_sort_with_binary_search.sv =====
// ----------------------------------------------------------------------------
// heap_sort_with_binary_search
// collects signed values in a row of cells, sorts them ascending on the
// last load, streams them out, and answers binary searches over the row
// ----------------------------------------------------------------------------
// load item: busy stays low unless the load is marked last
// last load: odd-even exchange phases, then the result stream, one sorted
//   element per cycle
// search item: key compare in every cell at accept, then one binary-search
//   step per cycle; no stall
// reset clears the count and marks the set closed; stored values stay as is
`default_nettype none

module heap_sort_with_binary_search #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   command,
    input  wire logic signed [hswbs_pkg::DATA_W-1:0]    value,
    input  wire logic                                   last,
    output logic                                        strobe,
    output logic                                        kind,
    output logic signed [hswbs_pkg::DATA_W-1:0]         data,
    output logic signed [hswbs_pkg::POS_W-1:0]          position,
    output logic                                        final_res
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);   // holds 0..MAX_ELEMENTS
    localparam int IDX_W = $clog2(MAX_ELEMENTS);       // cell index
    localparam int SRC_W = CNT_W + 1;                  // signed low/high bounds
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ELEMENTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT,
        ST_SEARCH
    } state_t;

    state_t                               state_reg;
    logic [CNT_W-1:0]                     count_reg;
    logic                                 closed_reg;
    logic [CNT_W-1:0]                     step_reg;
    logic                                 phase_reg;
    logic signed [SRC_W-1:0]              lo_reg;
    logic signed [SRC_W-1:0]              hi_reg;

    logic                                 strobe_reg;
    logic                                 kind_reg;
    logic signed [hswbs_pkg::DATA_W-1:0]  data_reg;
    logic signed [hswbs_pkg::POS_W-1:0]   position_reg;
    logic                                 final_reg;

    // cell row
    hswbs_pkg::cell_ctrl_t                cell_ctrl;
    logic [CNT_W-1:0]                     cell_count;
    logic signed [hswbs_pkg::DATA_W-1:0]  cell_val [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]              gt_vec;
    logic [MAX_ELEMENTS-1:0]              eq_vec;
    logic [MAX_ELEMENTS-1:0]              lt_vec;

    // load bookkeeping: a load after a finished set starts over at zero
    logic [CNT_W-1:0]                     base_cnt;
    logic                                 room;
    logic                                 accept;
    logic                                 last_step;

    // binary search step
    logic signed [SRC_W:0]                sum_w;
    logic [IDX_W-1:0]                     mid;
    logic signed [SRC_W-1:0]              mid_s;
    logic                                 in_range;

    assign accept    = start && (state_reg == ST_IDLE);
    assign base_cnt  = closed_reg ? '0 : count_reg;
    assign room      = base_cnt < MAX_C;
    assign last_step = step_reg == (count_reg - CNT_W'(1));

    assign in_range  = lo_reg <= hi_reg;
    assign sum_w     = {lo_reg[SRC_W-1], lo_reg} + {hi_reg[SRC_W-1], hi_reg};
    assign mid       = sum_w[IDX_W:1];
    assign mid_s     = $signed({{(SRC_W - IDX_W){1'b0}}, mid});

    assign busy      = state_reg != ST_IDLE;
    assign strobe    = strobe_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign position  = position_reg;
    assign final_res = final_reg;

    // cells see the load target count while idle, the set size otherwise
    assign cell_count = (state_reg == ST_IDLE) ? base_cnt : count_reg;

    always_comb
    begin
        cell_ctrl.op    = hswbs_pkg::CELL_HOLD;
        cell_ctrl.phase = phase_reg;
        cell_ctrl.data  = value;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == hswbs_pkg::CMD_SEARCH)
                    begin
                        cell_ctrl.op = hswbs_pkg::CELL_MATCH;
                    end
                    else if (room)
                    begin
                        cell_ctrl.op = hswbs_pkg::CELL_LOAD;
                    end
                end
            end
            ST_SORT:
            begin
                cell_ctrl.op = hswbs_pkg::CELL_SWAP;
            end
            ST_EMIT:
            begin
                cell_ctrl.op = hswbs_pkg::CELL_ROTATE;
            end
            default:
            begin
                cell_ctrl.op = hswbs_pkg::CELL_HOLD;
            end
        endcase
    end

    // row of cells: each compares with its right neighbor and shifts left
    for (genvar g = 0; g < MAX_ELEMENTS; g++)
    begin : g_cell
        logic signed [hswbs_pkg::DATA_W-1:0] left_w;
        logic signed [hswbs_pkg::DATA_W-1:0] right_w;
        logic                                gt_in_w;

        if (g == 0)
        begin : g_first
            assign left_w  = cell_val[0];
            assign gt_in_w = 1'b0;
        end
        else
        begin : g_inner
            assign left_w  = cell_val[g-1];
            assign gt_in_w = gt_vec[g-1];
        end

        if (g == MAX_ELEMENTS - 1)
        begin : g_last
            assign right_w = cell_val[g];
        end
        else
        begin : g_body
            assign right_w = cell_val[g+1];
        end

        hswbs_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .count     (cell_count),
            .left_val  (left_w),
            .right_val (right_w),
            .head_val  (cell_val[0]),
            .gt_in     (gt_in_w),
            .val       (cell_val[g]),
            .gt_out    (gt_vec[g]),
            .eq_flag   (eq_vec[g]),
            .lt_flag   (lt_vec[g])
        );
    end

    // controller: state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            closed_reg   <= 1'b1;
            step_reg     <= '0;
            phase_reg    <= 1'b0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            strobe_reg   <= 1'b0;
            kind_reg     <= hswbs_pkg::KIND_SORTED;
            data_reg     <= '0;
            position_reg <= '0;
            final_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (command == hswbs_pkg::CMD_SEARCH)
                        begin
                            // flags settle in the cells at this edge
                            lo_reg    <= '0;
                            hi_reg    <= $signed({1'b0, count_reg}) - SRC_W'(1);
                            state_reg <= ST_SEARCH;
                        end
                        else
                        begin
                            // dropped loads still count toward closing the set
                            count_reg  <= base_cnt + CNT_W'(room);
                            closed_reg <= last;
                            if (last)
                            begin
                                step_reg  <= '0;
                                phase_reg <= 1'b0;
                                state_reg <= ST_SORT;
                            end
                        end
                    end
                end
                ST_SORT:
                begin
                    // n exchange phases sort n values
                    phase_reg <= ~phase_reg;
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + CNT_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    // cell zero holds the next element; the row rotates back
                    // into sorted order once every element has gone out
                    strobe_reg   <= 1'b1;
                    kind_reg     <= hswbs_pkg::KIND_SORTED;
                    data_reg     <= cell_val[0];
                    position_reg <= hswbs_pkg::POS_W'(step_reg);
                    final_reg    <= last_step;
                    if (last_step)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + CNT_W'(1);
                    end
                end
                ST_SEARCH:
                begin
                    if (!in_range)
                    begin
                        strobe_reg   <= 1'b1;
                        kind_reg     <= hswbs_pkg::KIND_SEARCH;
                        data_reg     <= '0;
                        position_reg <= hswbs_pkg::POS_NONE;
                        final_reg    <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                    else if (eq_vec[mid])
                    begin
                        strobe_reg   <= 1'b1;
                        kind_reg     <= hswbs_pkg::KIND_SEARCH;
                        data_reg     <= '0;
                        position_reg <= hswbs_pkg::POS_W'(mid);
                        final_reg    <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                    else if (lt_vec[mid])
                    begin
                        hi_reg <= mid_s - SRC_W'(1);
                    end
                    else
                    begin
                        lo_reg <= mid_s + SRC_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/hswbs_checker.sv =====
// ----------------------------------------------------------------------------
// hswbs_checker
// port-level checks on the result stream of the sorting and search block
// ----------------------------------------------------------------------------
`default_nettype none

module hswbs_checker (
    input wire logic                                    clk,
    input wire logic                                    rst_n,
    input wire logic                                    strobe,
    input wire logic                                    kind,
    input wire logic signed [hswbs_pkg::DATA_W-1:0]     data,
    input wire logic signed [hswbs_pkg::POS_W-1:0]      position,
    input wire logic                                    final_res
);

    // a search answers with one zero-data item
    a_search_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == hswbs_pkg::KIND_SEARCH) |-> final_res && (data == '0))
        else $error("search answer not a single zero-data item");

    // the last item of a burst is followed by a quiet cycle
    a_gap_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && final_res |=> !strobe)
        else $error("result right after a final item");

    // sorted items come back to back with rising positions
    a_sorted_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == hswbs_pkg::KIND_SORTED) && !final_res |=>
            strobe && (kind == hswbs_pkg::KIND_SORTED) &&
            (position == $past(position) + 5'sd1))
        else $error("sorted burst broken or positions out of order");

    // sorted items ascend
    a_sorted_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == hswbs_pkg::KIND_SORTED) && !final_res |=>
            data >= $past(data))
        else $error("sorted items not ascending");

endmodule

bind heap_sort_with_binary_search hswbs_checker u_hswbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .strobe    (strobe),
    .kind      (kind),
    .data      (data),
    .position  (position),
    .final_res (final_res)
);

`default_nettype wire

// ===== tb/heap_sort_with_binary_search_tb.sv =====
// ----------------------------------------------------------------------------
// heap_sort_with_binary_search_tb
// drives load and search items through the start/busy handshake, predicts
// every sorted element and search answer in a scoreboard, and checks each
// strobed result field by field in arrival order
// ----------------------------------------------------------------------------
module heap_sort_with_binary_search_tb;

    localparam int MAX_ELEMENTS = 16;
    localparam int STALL_LIMIT  = 1000;   // cycles with no item and no result
    localparam int RANDOM_ITEMS = 95;
    localparam int QUIET_TAIL   = 25;     // last random items go without gaps
    localparam int DRAIN_CYCLES = 20;

    localparam logic signed [hswbs_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(hswbs_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [hswbs_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(hswbs_pkg::DATA_W-1){1'b1}}};

    // one strobed result as the block presents it
    typedef struct packed {
        logic                                   kind;
        logic signed [hswbs_pkg::DATA_W-1:0]    data;
        logic signed [hswbs_pkg::POS_W-1:0]     position;
        logic                                   final_res;
    } sort_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the element row, the count and the set state
    // ------------------------------------------------------------------------
    class sort_search_scoreboard;
        logic signed [hswbs_pkg::DATA_W-1:0] row [MAX_ELEMENTS];
        int unsigned              count;
        bit                       closed;
        sort_result_t             pending [$];
        int                       errors;

        function new();
            count  = 0;
            closed = 1'b1;
            errors = 0;
        endfunction

        // max-heap sift from root over the first size entries
        function void sift_down(int unsigned size, int unsigned root);
            int unsigned cur;
            int unsigned big;
            logic signed [hswbs_pkg::DATA_W-1:0] t;
            cur = root;
            while (1'b1)
            begin
                big = cur;
                if (2 * cur + 1 < size && row[2 * cur + 1] > row[big])
                    big = 2 * cur + 1;
                if (2 * cur + 2 < size && row[2 * cur + 2] > row[big])
                    big = 2 * cur + 2;
                if (big == cur)
                    return;
                t        = row[cur];
                row[cur] = row[big];
                row[big] = t;
                cur      = big;
            end
        endfunction

        // heapify, then move the root to the tail one entry at a time
        function void heap_order(int unsigned n);
            logic signed [hswbs_pkg::DATA_W-1:0] t;
            for (int unsigned i = n / 2; i > 0; i--)
                sift_down(n, i - 1);
            for (int unsigned i = n; i > 0; i--)
            begin
                t          = row[0];
                row[0]     = row[i - 1];
                row[i - 1] = t;
                sift_down(i - 1, 0);
            end
        endfunction

        // binary search over the current count, floor midpoint, -1 on miss
        function int find_key(logic signed [hswbs_pkg::DATA_W-1:0] key);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = int'(count) - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (row[mid] == key)
                    return mid;
                if (key < row[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return -1;
        endfunction

        function void note_item(logic cmd, logic signed [hswbs_pkg::DATA_W-1:0] val,
                                logic lst);
            sort_result_t r;
            int           idx;
            if (cmd == hswbs_pkg::CMD_SEARCH)
            begin
                // last is ignored on a search, and the row is left alone
                idx         = find_key(val);
                r.kind      = hswbs_pkg::KIND_SEARCH;
                r.data      = '0;
                r.position  = (idx < 0) ? hswbs_pkg::POS_NONE : idx[hswbs_pkg::POS_W-1:0];
                r.final_res = 1'b1;
                pending.push_back(r);
                return;
            end
            // a load after a finished set opens a new one
            if (closed)
            begin
                count  = 0;
                closed = 1'b0;
            end
            // loads beyond the row size are dropped, count saturates
            if (count < MAX_ELEMENTS)
            begin
                row[count] = val;
                count++;
            end
            if (!lst)
                return;
            heap_order(count);
            closed = 1'b1;
            for (int unsigned k = 0; k < count; k++)
            begin
                r.kind      = hswbs_pkg::KIND_SORTED;
                r.data      = row[k];
                r.position  = k[hswbs_pkg::POS_W-1:0];
                r.final_res = (k + 1 == count);
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic k, logic signed [hswbs_pkg::DATA_W-1:0] d,
                                   logic signed [hswbs_pkg::POS_W-1:0] p, logic f);
            sort_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with none expected: kind %0b data %0d position %0d final_res %0b",
                       k, d, p, f);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (k !== exp_r.kind)
            begin
                $error("kind: expected %0b, actual %0b", exp_r.kind, k);
                errors++;
            end
            if (d !== exp_r.data)
            begin
                $error("data: expected %0d, actual %0d", exp_r.data, d);
                errors++;
            end
            if (p !== exp_r.position)
            begin
                $error("position: expected %0d, actual %0d", exp_r.position, p);
                errors++;
            end
            if (f !== exp_r.final_res)
            begin
                $error("final_res: expected %0b, actual %0b", exp_r.final_res, f);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, block ports and instance
    // ------------------------------------------------------------------------
    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic                                   command;
    logic signed [hswbs_pkg::DATA_W-1:0]    value;
    logic                                   last;
    logic                                   strobe;
    logic                                   kind;
    logic signed [hswbs_pkg::DATA_W-1:0]    data;
    logic signed [hswbs_pkg::POS_W-1:0]     position;
    logic                                   final_res;

    sort_search_scoreboard                  sb;
    int                                     items_sent;
    bit                                     gaps_on;
    int                                     stall_cycles;
    logic signed [hswbs_pkg::DATA_W-1:0]    loaded_values [$];

    always #5 clk = ~clk;

    heap_sort_with_binary_search #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .last      (last),
        .strobe    (strobe),
        .kind      (kind),
        .data      (data),
        .position  (position),
        .final_res (final_res)
    );

    // ------------------------------------------------------------------------
    // monitor: results are checked before the item accepted on the same edge
    // is noted, since that item cannot have produced anything yet
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                sb.check_result(kind, data, position, final_res);
            if (start && !busy)
                sb.note_item(command, value, last);
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("heap_sort_with_binary_search test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // hold one item on the ports until the block takes it; start stays high
    // on return so a back-to-back item needs no second assignment
    task automatic issue_item(input logic cmd,
                              input logic signed [hswbs_pkg::DATA_W-1:0] val,
                              input logic lst);
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        last    <= lst;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    // random idle burst between items
    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // narrow values collide often, so searches hit and duplicates get sorted
    function automatic logic signed [hswbs_pkg::DATA_W-1:0] random_value(bit narrow);
        logic signed [hswbs_pkg::DATA_W-1:0] v;
        if (narrow)
            v = $signed($urandom_range(0, 16)) - 8;
        else
            v = $urandom;
        return v;
    endfunction

    // mostly keys from the current set, some that are likely absent
    function automatic logic signed [hswbs_pkg::DATA_W-1:0] search_key(bit narrow);
        if (loaded_values.size() != 0 && $urandom_range(0, 2) != 0)
            return loaded_values[$urandom_range(0, loaded_values.size() - 1)];
        return random_value(narrow);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int  random_goal;
        int  set_size;
        int  roll;
        bit  narrow;

        sb           = new();
        items_sent   = 0;
        gaps_on      = 1'b1;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = hswbs_pkg::CMD_LOAD;
        value        = '0;
        last         = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // search right after reset: empty set, last set on a search is ignored
        issue_item(hswbs_pkg::CMD_SEARCH, '0, 1'b1);
        sender_gap();

        // extremes loaded unsorted, searched while the set is still open and after it is sorted
        issue_item(hswbs_pkg::CMD_LOAD, VAL_MAX, 1'b0);
        issue_item(hswbs_pkg::CMD_LOAD, VAL_MIN, 1'b0);
        sender_gap();
        issue_item(hswbs_pkg::CMD_LOAD, -1, 1'b0);
        issue_item(hswbs_pkg::CMD_SEARCH, -1, 1'b0);
        sender_gap();
        issue_item(hswbs_pkg::CMD_LOAD, '0, 1'b1);
        issue_item(hswbs_pkg::CMD_SEARCH, VAL_MAX, 1'b0);
        sender_gap();

        // a single-element set opened after a finished one
        issue_item(hswbs_pkg::CMD_LOAD, 7, 1'b1);
        sender_gap();

        // overflow: the seventeenth load is dropped but its last mark sorts
        for (int k = 0; k < MAX_ELEMENTS + 1; k++)
        begin
            if (k == 3)
                issue_item(hswbs_pkg::CMD_LOAD, VAL_MIN, 1'b0);
            else if (k == MAX_ELEMENTS)
                issue_item(hswbs_pkg::CMD_LOAD, 99, 1'b1);
            else
                issue_item(hswbs_pkg::CMD_LOAD, (k * 7) % 5 - 2, 1'b0);
            sender_gap();
        end
        issue_item(hswbs_pkg::CMD_SEARCH, 99, 1'b0);
        sender_gap();

        // random part: mostly whole sets with searches mixed in, some noise
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            gaps_on = (items_sent < random_goal - QUIET_TAIL) && $urandom_range(0, 3) != 0;
            narrow  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 8)
            begin
                roll = $urandom_range(0, 19);
                if (roll < 14)
                    set_size = $urandom_range(1, 6);
                else if (roll < 18)
                    set_size = $urandom_range(7, MAX_ELEMENTS);
                else
                    set_size = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 3);
                loaded_values.delete();
                for (int k = 0; k < set_size; k++)
                begin
                    value_pick:
                    begin
                        logic signed [hswbs_pkg::DATA_W-1:0] v;
                        v = random_value(narrow);
                        if (k < MAX_ELEMENTS)
                            loaded_values.push_back(v);
                        issue_item(hswbs_pkg::CMD_LOAD, v, k == set_size - 1);
                    end
                    sender_gap();
                    // search inside an open set runs over unsorted entries
                    if (k != set_size - 1 && $urandom_range(0, 4) == 0)
                    begin
                        issue_item(hswbs_pkg::CMD_SEARCH, search_key(narrow),
                                   1'($urandom_range(0, 1)));
                        sender_gap();
                    end
                end
                repeat ($urandom_range(0, 3))
                begin
                    issue_item(hswbs_pkg::CMD_SEARCH, search_key(narrow),
                               1'($urandom_range(0, 1)));
                    sender_gap();
                end
            end
            else
            begin
                // noise: any command, value and last mark
                issue_item(1'($urandom_range(0, 1)), random_value(narrow),
                           1'($urandom_range(0, 1)));
                sender_gap();
            end
        end

        // close any set left open so its contents come out too
        issue_item(hswbs_pkg::CMD_LOAD, random_value(1'b0), 1'b1);
        start <= 1'b0;

        // drain, the watchdog bounds the wait
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("heap_sort_with_binary_search test passed");
        else
            $display("heap_sort_with_binary_search test failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/hswbs_pkg.sv
design/hswbs_cell.sv
design/heap_sort_with_binary_search.sv
design/hswbs_checker.sv
tb/heap_sort_with_binary_search_tb.sv
